// ===== rtl/output_power_meter_averager_macros.svh =====
// Assertion macros shared by the power meter averager RTL.
// No dependencies; included by modules that carry assertions.
`ifndef OUTPUT_POWER_METER_AVERAGER_MACROS_SVH
`define OUTPUT_POWER_METER_AVERAGER_MACROS_SVH

// same-cycle implication
`define OPMA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OPMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/opma_pkg.sv =====
// Package for the power meter averager: widths, types and register codes.
// Used by every module of the block.
`default_nettype none

package opma_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 24;
   localparam int PSUM_W     = 30;
   localparam int CNT_W      = 8;
   localparam int SCALE_W    = 16;
   localparam int GAIN_W     = 13;
   localparam int PWR_SHIFT  = 10;
   localparam int Q12_SHIFT  = 12;
   localparam int CAL_W      = 17;
   localparam int PCAL_W     = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int NUM_LANES  = 4;
   localparam int DIV_W      = PSUM_W;
   localparam int LANE_POWER = 0;
   localparam int LANE_VEXT  = 1;
   localparam int LANE_VINT  = 2;
   localparam int LANE_CURR  = 3;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [CNT_W-1:0]    WINDOW_RST = 8'd64;
   localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd4096;
   localparam logic [GAIN_W-1:0]   GAIN_RST   = 13'd4096;
   localparam logic [SAMPLE_W-1:0] PWR_SAT    = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_COUNT = 2'd0,
      CSR_POWER_SCALE  = 2'd1,
      CSR_VOLTAGE_GAIN = 2'd2,
      CSR_CURRENT_GAIN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  current_gain;
      logic [GAIN_W-1:0]  voltage_gain;
      logic [SCALE_W-1:0] power_scale;
      logic [CNT_W-1:0]   window_count;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] curr_sample;
      logic [SAMPLE_W-1:0] volt_int;
      logic [SAMPLE_W-1:0] volt_ext;
   } req_type;

   typedef struct packed {
      logic [PSUM_W-1:0] power_sum;
      logic [SUM_W-1:0]  vext_sum;
      logic [SUM_W-1:0]  vint_sum;
      logic [SUM_W-1:0]  curr_sum;
      logic [CNT_W-1:0]  count;
   } window_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [2:0]          pad;
      logic [CAL_W-1:0]    curr_cal;
      logic [SAMPLE_W-1:0] curr_avg;
      logic [CAL_W-1:0]    vint_cal;
      logic [SAMPLE_W-1:0] vint_avg;
      logic [CAL_W-1:0]    vext_cal;
      logic [SAMPLE_W-1:0] vext_avg;
      logic [PCAL_W-1:0]   power_cal;
      logic [SAMPLE_W-1:0] power_avg;
   } rsp_type;

   localparam int REQ_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);

endpackage

`default_nettype wire

// ===== rtl/opma_front.sv =====
// Front end: accepts sample words, keeps the running sums, closes windows.
// Depends on opma_pkg; pushes closed windows into opma_queue.
`default_nettype none

module opma_front import opma_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,
   input  wire logic [CNT_W-1:0]  window_count,
   input  wire q_status_type      q_stat,
   output logic                   push,
   output window_type             push_data
);

   logic [PSUM_W-1:0] psum_ff, psum_in;
   logic [SUM_W-1:0]  vext_ff, vext_in;
   logic [SUM_W-1:0]  vint_ff, vint_in;
   logic [SUM_W-1:0]  curr_ff, curr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   req_type           req;
   logic [2*SAMPLE_W-1:0] prod;
   logic [PSUM_W-1:0] psum_nx;
   logic [SUM_W-1:0]  vext_nx, vint_nx, curr_nx;
   logic [CNT_W-1:0]  count_nx;
   logic              accept, close;

   assign req        = req_type'(req_tdata);
   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   assign prod     = (2*SAMPLE_W)'(req.volt_int) * (2*SAMPLE_W)'(req.curr_sample);
   assign psum_nx  = psum_ff + PSUM_W'(prod[2*SAMPLE_W-1:PWR_SHIFT]);
   assign vext_nx  = vext_ff + SUM_W'(req.volt_ext);
   assign vint_nx  = vint_ff + SUM_W'(req.volt_int);
   assign curr_nx  = curr_ff + SUM_W'(req.curr_sample);
   assign count_nx = count_ff + CNT_W'(1);
   assign close    = count_nx >= window_count;

   assign push      = accept && close;
   assign push_data = '{power_sum: psum_nx, vext_sum: vext_nx, vint_sum: vint_nx,
                        curr_sum: curr_nx, count: count_nx};

   always_comb begin
      psum_in  = psum_ff;
      vext_in  = vext_ff;
      vint_in  = vint_ff;
      curr_in  = curr_ff;
      count_in = count_ff;
      if (accept) begin
         if (close) begin
            psum_in  = '0;
            vext_in  = '0;
            vint_in  = '0;
            curr_in  = '0;
            count_in = '0;
         end else begin
            psum_in  = psum_nx;
            vext_in  = vext_nx;
            vint_in  = vint_nx;
            curr_in  = curr_nx;
            count_in = count_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psum_ff  <= '0;
         vext_ff  <= '0;
         vint_ff  <= '0;
         curr_ff  <= '0;
         count_ff <= '0;
      end else begin
         psum_ff  <= psum_in;
         vext_ff  <= vext_in;
         vint_ff  <= vint_in;
         curr_ff  <= curr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/opma_queue.sv =====
// Short FIFO of closed windows between the front and back ends.
// Depends on opma_pkg and the assertion macros header.
`default_nettype none

`include "output_power_meter_averager_macros.svh"

module opma_queue import opma_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire window_type push_data,
   input  wire logic       pop,
   output window_type      head,
   output q_status_type    q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QCNT_W = $clog2(DEPTH + 1);

   window_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign q_stat.full  = count_ff == QCNT_W'(DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `OPMA_ASSERT_IMPL(a_no_overflow, clock, reset, push, !q_stat.full, "push into full queue")
   `OPMA_ASSERT_IMPL(a_no_underflow, clock, reset, pop, !q_stat.empty, "pop from empty queue")
   `OPMA_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !q_stat.empty, "push lost")

endmodule

`default_nettype wire

// ===== rtl/opma_divider.sv =====
// Multi-lane restoring divider, one quotient bit per lane per cycle.
// Depends on opma_pkg; all lanes share the divisor and the step counter.
`default_nettype none

module opma_divider import opma_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend [NUM_LANES],
   input  wire logic [CNT_W-1:0]  divisor,
   output logic [DIV_W-1:0]       quotient [NUM_LANES],
   output logic                   done
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  work_ff [NUM_LANES];
   logic [DIV_W-1:0]  work_in [NUM_LANES];
   logic [CNT_W-1:0]  rem_ff  [NUM_LANES];
   logic [CNT_W-1:0]  rem_in  [NUM_LANES];
   logic [CNT_W:0]    trial   [NUM_LANES];
   logic [CNT_W-1:0]  divisor_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              last;

   assign last = busy_ff && (step_ff == STEP_W'(1));

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         trial[i] = {rem_ff[i], work_ff[i][DIV_W-1]};
         if (trial[i] >= {1'b0, divisor_ff}) begin
            rem_in[i]  = CNT_W'(trial[i] - {1'b0, divisor_ff});
            work_in[i] = {work_ff[i][DIV_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = trial[i][CNT_W-1:0];
            work_in[i] = {work_ff[i][DIV_W-2:0], 1'b0};
         end
         quotient[i] = work_ff[i];
      end
      busy_in = start ? 1'b1 : (last ? 1'b0 : busy_ff);
      step_in = start ? STEP_W'(DIV_W) : (busy_ff ? step_ff - STEP_W'(1) : step_ff);
      done_in = last;
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         for (int i = 0; i < NUM_LANES; i++) begin
            work_ff[i] <= dividend[i];
            rem_ff[i]  <= '0;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            work_ff[i] <= work_in[i];
            rem_ff[i]  <= rem_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/opma_back.sv =====
// Back end: divides a closed window, applies scale and gains, holds the result word.
// Depends on opma_pkg, opma_divider and the assertion macros header.
`default_nettype none

`include "output_power_meter_averager_macros.svh"

module opma_back import opma_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire q_status_type      q_stat,
   input  wire window_type        head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_SCALE  = 6'b000100,
      ST_VGAIN  = 6'b001000,
      ST_CGAIN  = 6'b010000,
      ST_HOLD   = 6'b100000
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [DIV_W-1:0]        dividend [NUM_LANES];
   logic [DIV_W-1:0]        quotient [NUM_LANES];
   logic                    div_start, div_done;
   logic [PSUM_W-1:0]       pq_ff;
   logic [SAMPLE_W-1:0]     vea_ff, via_ff, cua_ff, pavg_ff;
   logic [CAL_W-1:0]        vec_ff, vic_ff, cuc_ff, pv_ff;
   logic [PCAL_W-1:0]       pcal_ff;
   logic [PSUM_W+SCALE_W-1:0]          pscaled;
   logic [SAMPLE_W+GAIN_W-1:0]         vec_prod, vic_prod, cuc_prod, pv_prod;
   logic [CAL_W+GAIN_W-1:0]            pcal_prod;
   logic                    capture, scale, vgain, cgain, load;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff;

   assign dividend[LANE_POWER] = DIV_W'(head.power_sum);
   assign dividend[LANE_VEXT]  = DIV_W'(head.vext_sum);
   assign dividend[LANE_VINT]  = DIV_W'(head.vint_sum);
   assign dividend[LANE_CURR]  = DIV_W'(head.curr_sum);

   opma_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (head.count),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      capture   = 1'b0;
      scale     = 1'b0;
      vgain     = 1'b0;
      cgain     = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop       = 1'b1;
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               capture  = 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            scale    = 1'b1;
            state_in = ST_VGAIN;
         end
         ST_VGAIN: begin
            vgain    = 1'b1;
            state_in = ST_CGAIN;
         end
         ST_CGAIN: begin
            cgain    = 1'b1;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign pscaled   = (PSUM_W+SCALE_W)'(pq_ff) * (PSUM_W+SCALE_W)'(cfg.power_scale);
   assign vec_prod  = (SAMPLE_W+GAIN_W)'(vea_ff) * (SAMPLE_W+GAIN_W)'(cfg.voltage_gain);
   assign vic_prod  = (SAMPLE_W+GAIN_W)'(via_ff) * (SAMPLE_W+GAIN_W)'(cfg.voltage_gain);
   assign cuc_prod  = (SAMPLE_W+GAIN_W)'(cua_ff) * (SAMPLE_W+GAIN_W)'(cfg.current_gain);
   assign pv_prod   = (SAMPLE_W+GAIN_W)'(pavg_ff) * (SAMPLE_W+GAIN_W)'(cfg.voltage_gain);
   assign pcal_prod = (CAL_W+GAIN_W)'(pv_ff) * (CAL_W+GAIN_W)'(cfg.current_gain);

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         pq_ff  <= PSUM_W'(quotient[LANE_POWER]);
         vea_ff <= quotient[LANE_VEXT][SAMPLE_W-1:0];
         via_ff <= quotient[LANE_VINT][SAMPLE_W-1:0];
         cua_ff <= quotient[LANE_CURR][SAMPLE_W-1:0];
      end
      if (scale) begin
         // saturate the Q12-scaled power average
         pavg_ff <= (|pscaled[PSUM_W+SCALE_W-1:Q12_SHIFT+SAMPLE_W]) ? PWR_SAT
                    : pscaled[Q12_SHIFT+SAMPLE_W-1:Q12_SHIFT];
         vec_ff  <= vec_prod[SAMPLE_W+GAIN_W-1:Q12_SHIFT];
         vic_ff  <= vic_prod[SAMPLE_W+GAIN_W-1:Q12_SHIFT];
         cuc_ff  <= cuc_prod[SAMPLE_W+GAIN_W-1:Q12_SHIFT];
      end
      if (vgain) begin
         pv_ff <= pv_prod[SAMPLE_W+GAIN_W-1:Q12_SHIFT];
      end
      if (cgain) begin
         pcal_ff <= pcal_prod[CAL_W+GAIN_W-1:Q12_SHIFT];
      end
      if (load) begin
         rsp_ff <= '{pad: 3'b000, curr_cal: cuc_ff, curr_avg: cua_ff,
                     vint_cal: vic_ff, vint_avg: via_ff,
                     vext_cal: vec_ff, vext_avg: vea_ff,
                     power_cal: pcal_ff, power_avg: pavg_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   `OPMA_ASSERT_IMPL(a_done_in_divide, clock, reset, div_done, state_ff == ST_DIVIDE, "divider done outside divide")
   `OPMA_ASSERT_NEXT(a_hold_stalls, clock, reset, state_ff == ST_HOLD && rsp_valid_ff && !rsp_tready, state_ff == ST_HOLD, "result overwritten while stalled")
   `OPMA_ASSERT_IMPL(a_pop_idle, clock, reset, pop, state_ff == ST_IDLE, "window popped while busy")

endmodule

`default_nettype wire

// ===== rtl/output_power_meter_averager.sv =====
// Boxcar-average output power meter: top level with configuration registers.
// Depends on opma_pkg, opma_front, opma_queue and opma_back.
//
// Usage:
//   req_ channel: one word per sample set (external voltage, internal
//   voltage, current). Every word adds into the running sums; the word that
//   brings the sample count to window_count closes the window.
//   rsp_ channel: one word per closed window with raw (power scaled by
//   power_scale) and Q12-calibrated averages of power, both voltages and current.
//   csr_ port: write window_count, power_scale, voltage_gain, current_gain
//   by index; write only while no window is in flight.
// From the closing req_ word to rsp_tvalid, the window passes through the queue
//   pop, the 30-step restoring divider (one quotient bit per cycle, four lanes),
//   quotient capture, three multiply steps and the output register load.
// The back end takes a new window only after loading the last result; req_ words
//   are taken one per cycle while the window queue has room.
// Reset clears the sums, counter, queue and output valid, and loads the
//   register defaults (64 samples, unity scale and gains).
// When the receiver stalls, the result word holds in the output register;
//   closed windows then collect in the queue, and req_tready drops when it fills.
`default_nettype none

module output_power_meter_averager import opma_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // volt_ext [15:0], volt_int [31:16], curr_sample [47:32]
   input  wire logic [REQ_W-1:0]      req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // power_avg [15:0], power_cal [33:16], vext_avg [49:34], vext_cal [66:50],
   // vint_avg [82:67], vint_cal [99:83], curr_avg [115:100], curr_cal [132:116]
   output logic [RSP_W-1:0]           rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_stat;
   window_type   push_data, head;
   logic         push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_COUNT: cfg_in.window_count = csr_wdata[CNT_W-1:0];
            CSR_POWER_SCALE:  cfg_in.power_scale  = csr_wdata[SCALE_W-1:0];
            CSR_VOLTAGE_GAIN: cfg_in.voltage_gain = csr_wdata[GAIN_W-1:0];
            CSR_CURRENT_GAIN: cfg_in.current_gain = csr_wdata[GAIN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{current_gain: GAIN_RST, voltage_gain: GAIN_RST,
                     power_scale: SCALE_RST, window_count: WINDOW_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   opma_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .window_count (cfg_ff.window_count),
      .q_stat       (q_stat),
      .push         (push),
      .push_data    (push_data)
   );

   opma_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   opma_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_stat     (q_stat),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
